// ===== design/pqd_pkg.sv =====
package pqd_pkg;
  localparam int TableSets = 256;
  localparam int TableWays = 4;
  localparam int KeyW = 48;
  localparam int EntryW = 56;
  localparam logic [1:0] PrecisionRst = 2'd1;
  localparam logic DedupRst = 1'b1;
  localparam logic [8:0] ThreshRst = 9'd12;

  localparam logic [1:0] RegPrecision = 2'd0;
  localparam logic [1:0] RegDedup = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [7:0] inten;
    logic frame_start;
    logic dedup;
    logic [8:0] thresh;
  } point_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [7:0] inten;
    logic kept;
    logic full;
  } result_t;

  // Saturate a quotient (|q| < 2^32) to int16.
  function automatic logic [15:0] sat16(input logic signed [33:0] q);
    logic [15:0] r;
    if (q > 34'sd32767) r = 16'h7fff;
    else if (q < -34'sd32768) r = 16'h8000;
    else r = q[15:0];
    return r;
  endfunction
endpackage

// ===== design/pqd_ram.sv =====
module pqd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/pqd_front.sv =====
module pqd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic signed [31:0]  x_raw_i,
  input  logic signed [31:0]  y_raw_i,
  input  logic signed [31:0]  z_raw_i,
  input  logic signed [31:0]  intensity_raw_i,
  input  logic                frame_start_i,
  input  logic [1:0]          precision_i,
  input  logic                dedup_i,
  input  logic [8:0]          thresh_i,
  output logic                valid_o,
  input  logic                ready_i,
  output pqd_pkg::point_t     point_o
);
  import pqd_pkg::*;

  // Reciprocals exact for magnitudes below 2^26.
  localparam logic [26:0] Recip10   = 27'd107374183;
  localparam logic [26:0] Recip100  = 27'd85899346;
  localparam logic [26:0] Recip1000 = 27'd68719477;
  // floor(d * 256 / 4500) == floor(d * 64 / 1125) for d below 4500
  localparam logic [19:0] Recip1125 = 20'd954438;
  // any magnitude at or above 2^25 saturates for every divisor
  localparam logic [32:0] MagCap = 33'h0_0200_0000;
  localparam logic signed [32:0] IntenOffset = 33'sd500;
  localparam logic signed [32:0] IntenTop = 33'sd4500;

  localparam logic [1:0] Prec1    = 2'd0;
  localparam logic [1:0] Prec10   = 2'd1;
  localparam logic [1:0] Prec100  = 2'd2;
  localparam logic [1:0] Prec1000 = 2'd3;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [25:0] mag_q [3];
  logic        neg_q [3];
  logic [1:0]  prec_q;
  logic [18:0] inum_q;
  logic        ilow_q, ihigh_q;
  logic        fs_q, dd_q;
  logic [8:0]  th_q;
  point_t      pt_q;

  logic signed [32:0] craw [3];
  logic [32:0]        cabs [3];
  logic signed [32:0] idiff;
  logic [26:0]        recip;
  logic [52:0]        prod [3];
  logic [25:0]        quo [3];
  logic [38:0]        iprod;

  assign craw[0] = 33'(x_raw_i);
  assign craw[1] = -33'(y_raw_i);
  assign craw[2] = -33'(z_raw_i);
  assign idiff = 33'(intensity_raw_i) - IntenOffset;
  assign iprod = 39'(inum_q) * 39'(Recip1125);

  always_comb begin
    unique case (prec_q)
      Prec10: recip = Recip10;
      Prec100: recip = Recip100;
      Prec1000: recip = Recip1000;
      default: recip = '0;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cabs[c] = craw[c][32] ? 33'(-craw[c]) : 33'(craw[c]);
      prod[c] = 53'(mag_q[c]) * 53'(recip);
      unique case (prec_q)
        Prec1: quo[c] = mag_q[c];
        Prec10: quo[c] = 26'(prod[c] >> 30);
        Prec100: quo[c] = 26'(prod[c] >> 33);
        default: quo[c] = 26'(prod[c] >> 36);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (push_i) state_d = StCalc;
      StCalc: state_d = StOut;
      StOut: if (ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && push_i) begin
      for (int c = 0; c < 3; c++) begin
        neg_q[c] <= craw[c][32];
        mag_q[c] <= (cabs[c] > MagCap) ? MagCap[25:0] : cabs[c][25:0];
      end
      prec_q <= precision_i;
      ilow_q <= idiff[32];
      ihigh_q <= !idiff[32] && idiff >= IntenTop;
      inum_q <= {idiff[12:0], 6'd0};
      fs_q <= frame_start_i;
      dd_q <= dedup_i;
      th_q <= thresh_i;
    end else if (state_q == StCalc) begin
      pt_q.x <= sat16(neg_q[0] ? -34'(quo[0]) : 34'(quo[0]));
      pt_q.y <= sat16(neg_q[1] ? -34'(quo[1]) : 34'(quo[1]));
      pt_q.z <= sat16(neg_q[2] ? -34'(quo[2]) : 34'(quo[2]));
      pt_q.inten <= ilow_q ? 8'd0 : ihigh_q ? 8'hff : iprod[37:30];
      pt_q.frame_start <= fs_q;
      pt_q.dedup <= dd_q;
      pt_q.thresh <= th_q;
    end
  end

  assign full_o = state_q != StIdle;
  assign valid_o = state_q == StOut;
  assign point_o = pt_q;
endmodule

// ===== design/pqd_back.sv =====
module pqd_back #(
  parameter int TableSets = pqd_pkg::TableSets,
  parameter int TableWays = pqd_pkg::TableWays
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  pqd_pkg::point_t  point_i,
  output logic             empty_o,
  input  logic             pop_i,
  output pqd_pkg::result_t result_o
);
  import pqd_pkg::*;

  localparam int SetW = (TableSets > 1) ? $clog2(TableSets) : 1;
  localparam int WayW = (TableWays > 1) ? $clog2(TableWays) : 1;
  localparam int Depth = TableSets * TableWays;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EpochW = 16;
  // set index by reciprocal multiply, exact for a 16-bit hash
  localparam int SetShift = 16 + $clog2(TableSets);
  localparam longint SetRecip =
    ((longint'(1) << SetShift) + longint'(TableSets) - 1) / longint'(TableSets);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  // Valid bits in a RAM tagged with a frame epoch; a sweep runs before the epoch wraps.
  localparam int VW = TableWays * (1 + EpochW);

  logic [1:0] state_q, state_d;
  logic [EpochW-1:0] epoch_q;
  logic clr_q;
  logic swept_q;
  logic [SetW-1:0] clr_idx_q;
  point_t pt_q;
  result_t res_q;
  logic res_v_q;
  logic [SetW-1:0] set_q;

  logic [15:0] hsh;
  logic [33:0] set_prod;
  logic [16:0] set_quo;
  logic [16:0] set_rem;
  logic [SetW-1:0] set_c;
  assign hsh = point_i.x ^ point_i.y ^ point_i.z;
  assign set_prod = 34'(hsh) * 34'(SetRecip);
  assign set_quo = 17'(set_prod >> SetShift);
  assign set_rem = 17'(34'(hsh) - 34'(set_quo) * 34'(TableSets));
  assign set_c = SetW'(set_rem);

  logic [VW-1:0] vrd, vwd;
  logic vwe;
  logic [SetW-1:0] vwa;
  logic [EntryW-1:0] erd [TableWays];
  logic ewe [TableWays];

  pqd_ram #(.Width(VW), .Depth(TableSets)) u_vram (
    .clk_i, .we_i(vwe), .waddr_i(vwa), .wdata_i(vwd), .raddr_i(set_c), .rdata_o(vrd));

  for (genvar w = 0; w < TableWays; w++) begin : g_way
    pqd_ram #(.Width(EntryW), .Depth(TableSets)) u_eram (
      .clk_i, .we_i(ewe[w]), .waddr_i(set_q), .wdata_i({pt_q.x, pt_q.y, pt_q.z, pt_q.inten}),
      .raddr_i(set_c), .rdata_o(erd[w]));
  end

  logic [EpochW-1:0] ep_c;
  assign ep_c = epoch_q + EpochW'(pt_q.frame_start);

  logic [TableWays-1:0] vbit, hit;
  logic found;
  logic [WayW-1:0] fway;
  always_comb begin
    logic [7:0] s, d;
    found = 1'b0;
    fway = '0;
    for (int w = TableWays - 1; w >= 0; w--) begin
      vbit[w] = vrd[w*(1+EpochW)] && vrd[w*(1+EpochW)+1 +: EpochW] == ep_c;
      s = erd[w][7:0];
      d = (s > pt_q.inten) ? s - pt_q.inten : pt_q.inten - s;
      hit[w] = vbit[w] && erd[w][EntryW-1:8] == {pt_q.x, pt_q.y, pt_q.z}
               && {1'b0, d} < pt_q.thresh;
      if (!vbit[w]) begin
        found = 1'b1;
        fway = WayW'(w);
      end
    end
  end

  logic kept_c;
  assign kept_c = !(pt_q.dedup && |hit);

  always_comb begin
    vwe = 1'b0;
    vwa = set_q;
    vwd = vrd;
    for (int w = 0; w < TableWays; w++) ewe[w] = 1'b0;
    if (clr_q) begin
      vwe = 1'b1;
      vwa = clr_idx_q;
      vwd = '0;
    end else if (state_q == StRead && pt_q.dedup && kept_c && found) begin
      vwe = 1'b1;
      for (int w = 0; w < TableWays; w++)
        if (!vbit[w]) vwd[w*(1+EpochW) +: 1+EpochW] = {ep_c, 1'b0};
      vwd[32'(fway)*(1+EpochW) +: 1+EpochW] = {ep_c, 1'b1};
      ewe[fway] = 1'b1;
    end
  end

  // a frame start that wraps the epoch waits for a full sweep first
  logic wrap_c, sweep_start;
  assign wrap_c = point_i.frame_start && (&epoch_q);
  assign sweep_start = state_q == StIdle && valid_i && !clr_q && !res_v_q && wrap_c
                       && !swept_q;

  assign ready_o = state_q == StIdle && !clr_q && !res_v_q && !(wrap_c && !swept_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (valid_i && ready_o) state_d = StRead;
      StRead: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      epoch_q <= '0;
      clr_q <= 1'b1;
      swept_q <= 1'b0;
      clr_idx_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        if (32'(clr_idx_q) == TableSets - 1) begin
          clr_q <= 1'b0;
          clr_idx_q <= '0;
        end else begin
          clr_idx_q <= clr_idx_q + SetW'(1);
        end
      end else if (sweep_start) begin
        clr_q <= 1'b1;
        swept_q <= 1'b1;
      end
      if (state_q == StRead) begin
        epoch_q <= ep_c;
        swept_q <= 1'b0;
        res_v_q <= 1'b1;
      end else if (pop_i && res_v_q) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pt_q <= point_i;
      set_q <= set_c;
    end
    if (state_q == StRead) begin
      res_q.x <= pt_q.x;
      res_q.y <= pt_q.y;
      res_q.z <= pt_q.z;
      res_q.inten <= pt_q.inten;
      res_q.kept <= kept_c;
      res_q.full <= pt_q.dedup && kept_c && !found;
    end
  end

  assign empty_o = !res_v_q;
  assign result_o = res_q;

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(ewe[0])) else $error("entry write during sweep");
  a_drop_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !res_q.kept |-> !res_q.full) else $error("dropped point flagged full");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> !ready_o) else $error("accept with pending result");
endmodule

// ===== design/point_quantize_dedup.sv =====
// Channel | Handshake | Ports
// in      | push/full | x_raw_i y_raw_i z_raw_i intensity_raw_i frame_start_i
// out     | pop/empty | x_out_o y_out_o z_out_o intensity_out_o kept_o table_full_o
// cfg     | cfg_we_i  | cfg_idx_i cfg_data_i
// Front: capture magnitudes, then reciprocal multiply and saturate; back: table read,
// compare/write into the result register.
// A waiting result stalls the back, and the front then reports full.
// After reset, and before a frame start that wraps the frame epoch, a sweep over all
// TableSets sets clears the valid RAM; points wait, configuration writes are taken.
module point_quantize_dedup #(
  parameter int TableSets = pqd_pkg::TableSets,
  parameter int TableWays = pqd_pkg::TableWays
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] x_raw_i,
  input  logic signed [31:0] y_raw_i,
  input  logic signed [31:0] z_raw_i,
  input  logic signed [31:0] intensity_raw_i,
  input  logic               frame_start_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] x_out_o,
  output logic signed [15:0] y_out_o,
  output logic signed [15:0] z_out_o,
  output logic [7:0]         intensity_out_o,
  output logic               kept_o,
  output logic               table_full_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [8:0]         cfg_data_i
);
  import pqd_pkg::*;

  logic [1:0] prec_q;
  logic dedup_q;
  logic [8:0] thresh_q;
  logic fv, fr;
  point_t pt;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= PrecisionRst;
      dedup_q <= DedupRst;
      thresh_q <= ThreshRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPrecision: prec_q <= cfg_data_i[1:0];
        RegDedup: dedup_q <= cfg_data_i[0];
        RegThresh: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pqd_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .x_raw_i, .y_raw_i, .z_raw_i,
    .intensity_raw_i, .frame_start_i, .precision_i(prec_q), .dedup_i(dedup_q),
    .thresh_i(thresh_q), .valid_o(fv), .ready_i(fr), .point_o(pt));

  pqd_back #(.TableSets(TableSets), .TableWays(TableWays)) u_back (
    .clk_i, .rst_ni, .valid_i(fv), .ready_o(fr), .point_i(pt),
    .empty_o(empty), .pop_i(pop), .result_o(res));

  assign x_out_o = res.x;
  assign y_out_o = res.y;
  assign z_out_o = res.z;
  assign intensity_out_o = res.inten;
  assign kept_o = res.kept;
  assign table_full_o = res.full;
endmodule
